[rtl/nta_pkg.sv]
package nta_pkg;

    // table geometry
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // field widths
    localparam int OP_W     = 2;
    localparam int ID_W     = 8;
    localparam int WT_W     = 7;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int EVICT_W  = 5;

    // configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // register reset values
    localparam logic [WT_W-1:0] THRESHOLD_RST = 7'd50;
    localparam logic [WT_W-1:0] INCREMENT_RST = 7'd10;
    localparam logic [WT_W-1:0] CAP_RST       = 7'd100;

    localparam logic [EVICT_W-1:0] EVICT_MAX = '1;
    localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(ENTRIES - 1);

    // register indexes (word address)
    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_INCREMENT = 2'd1,
        REG_CAP       = 2'd2
    } reg_idx_t;

    typedef enum logic [OP_W-1:0] {
        OP_RECV  = 2'd0,
        OP_TICK  = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_UPDATED  = 3'd0,
        ST_INSERTED = 3'd1,
        ST_FULL     = 3'd2,
        ST_TICK     = 3'd3,
        ST_HIT      = 3'd4,
        ST_MISS     = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    typedef struct packed {
        logic [WT_W-1:0] threshold;
        logic [WT_W-1:0] increment;
        logic [WT_W-1:0] cap;
    } cfg_t;

    // controller -> datapath
    typedef struct packed {
        logic start;
        logic step;
        logic load_out;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
    } sts_t;

endpackage

[rtl/nta_regs.sv]
module nta_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nta_pkg::PADDR_W-1:0]   paddr,
    input  logic [nta_pkg::PDATA_W-1:0]   pwdata,
    output logic [nta_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output nta_pkg::cfg_t                 cfg
);

    logic [nta_pkg::WT_W-1:0] threshold_reg;
    logic [nta_pkg::WT_W-1:0] increment_reg;
    logic [nta_pkg::WT_W-1:0] cap_reg;
    logic                     wr_en;
    logic [1:0]               word_addr;

    assign pready    = 1'b1;
    assign wr_en     = psel & penable & pwrite;
    assign word_addr = paddr[3:2];

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= nta_pkg::THRESHOLD_RST;
            increment_reg <= nta_pkg::INCREMENT_RST;
            cap_reg       <= nta_pkg::CAP_RST;
        end else if (wr_en) begin
            unique case (word_addr)
                nta_pkg::REG_THRESHOLD: threshold_reg <= pwdata[nta_pkg::WT_W-1:0];
                nta_pkg::REG_INCREMENT: increment_reg <= pwdata[nta_pkg::WT_W-1:0];
                nta_pkg::REG_CAP:       cap_reg       <= pwdata[nta_pkg::WT_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (word_addr)
            nta_pkg::REG_THRESHOLD: prdata = nta_pkg::PDATA_W'(threshold_reg);
            nta_pkg::REG_INCREMENT: prdata = nta_pkg::PDATA_W'(increment_reg);
            nta_pkg::REG_CAP:       prdata = nta_pkg::PDATA_W'(cap_reg);
            default:                prdata = '0;
        endcase
    end

    assign cfg.threshold = threshold_reg;
    assign cfg.increment = increment_reg;
    assign cfg.cap       = cap_reg;

endmodule

[rtl/nta_ctrl.sv]
module nta_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [nta_pkg::OP_W-1:0]   s_opcode,
    output logic                       m_valid,
    input  logic                       m_ready,
    output nta_pkg::cmd_t              cmd,
    input  nta_pkg::sts_t              sts
);

    nta_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;
    logic            out_free;

    assign s_ready  = (state_reg == nta_pkg::S_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            nta_pkg::S_IDLE: begin
                if (s_valid) begin
                    cmd.start = 1'b1;
                    if (s_opcode != nta_pkg::OP_NONE) begin
                        state_next = nta_pkg::S_SCAN;
                    end
                end
            end
            nta_pkg::S_SCAN: begin
                cmd.step = 1'b1;
                if (sts.scan_done) begin
                    state_next = nta_pkg::S_FINISH;
                end
            end
            nta_pkg::S_FINISH: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = nta_pkg::S_IDLE;
                end
            end
            default: state_next = nta_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= nta_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

[rtl/nta_dp.sv]
module nta_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  nta_pkg::cfg_t                  cfg,
    input  nta_pkg::cmd_t                  cmd,
    output nta_pkg::sts_t                  sts,
    input  logic [nta_pkg::OP_W-1:0]       s_opcode,
    input  logic [nta_pkg::ID_W-1:0]       s_source_id,
    input  logic [nta_pkg::ID_W-1:0]       s_dest_id,
    input  logic [nta_pkg::ID_W-1:0]       s_query_key,
    output logic [nta_pkg::STATUS_W-1:0]   m_status,
    output logic [nta_pkg::SLOT_W-1:0]     m_slot,
    output logic [nta_pkg::ID_W-1:0]       m_entry_id,
    output logic [nta_pkg::WT_W-1:0]       m_entry_weight,
    output logic [nta_pkg::EVICT_W-1:0]    m_evicted_count
);

    localparam int N  = nta_pkg::ENTRIES;
    localparam int IW = nta_pkg::IDX_W;
    localparam int DW = nta_pkg::ID_W;
    localparam int WW = nta_pkg::WT_W;
    localparam int EW = nta_pkg::EVICT_W;

    // slot table
    logic          valid_reg   [N];
    logic          trusted_reg [N];
    logic          unread_reg  [N];
    logic [DW-1:0] id_reg      [N];
    logic [DW-1:0] target_reg  [N];
    logic [WW-1:0] weight_reg  [N];

    // latched item and scan state
    nta_pkg::op_t  op_reg;
    logic [DW-1:0] src_reg;
    logic [DW-1:0] dst_reg;
    logic [DW-1:0] key_reg;
    logic [IW-1:0] idx_reg;
    logic [EW-1:0] evict_reg, evict_next;

    // pending result
    nta_pkg::status_t         res_status_reg, res_status_next;
    logic [nta_pkg::SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic [DW-1:0]            res_id_reg, res_id_next;
    logic [WW-1:0]            res_weight_reg, res_weight_next;
    logic [EW-1:0]            res_evict_reg, res_evict_next;

    // output beat
    logic [nta_pkg::STATUS_W-1:0] out_status_reg;
    logic [nta_pkg::SLOT_W-1:0]   out_slot_reg;
    logic [DW-1:0]                out_id_reg;
    logic [WW-1:0]                out_weight_reg;
    logic [EW-1:0]                out_evict_reg;

    // current slot view
    logic          cur_valid, cur_trusted, cur_unread;
    logic [DW-1:0] cur_id, cur_target;
    logic [WW-1:0] cur_weight;
    logic          id_match, tgt_match, is_last;
    logic [WW:0]   upd_sum;
    logic [WW-1:0] upd_weight, ins_weight, dec_weight;
    logic          done;
    logic          wr_upd, wr_ins, wr_tick, clr_unread;

    assign cur_valid   = valid_reg[idx_reg];
    assign cur_trusted = trusted_reg[idx_reg];
    assign cur_unread  = unread_reg[idx_reg];
    assign cur_id      = id_reg[idx_reg];
    assign cur_target  = target_reg[idx_reg];
    assign cur_weight  = weight_reg[idx_reg];

    assign id_match  = cur_valid && (cur_id == src_reg);
    assign tgt_match = cur_valid && (cur_target == key_reg);
    assign is_last   = (idx_reg == nta_pkg::LAST_IDX);

    // weight arithmetic
    assign upd_sum    = {1'b0, cur_weight} + {1'b0, cfg.increment};
    assign upd_weight = (upd_sum > {1'b0, cfg.cap}) ? cfg.cap : upd_sum[WW-1:0];
    assign ins_weight = (cfg.increment > cfg.cap) ? cfg.cap : cfg.increment;
    assign dec_weight = (cur_weight != '0) ? (cur_weight - WW'(1)) : '0;

    // per-slot decision
    always_comb begin
        done            = 1'b0;
        wr_upd          = 1'b0;
        wr_ins          = 1'b0;
        wr_tick         = 1'b0;
        clr_unread      = 1'b0;
        evict_next      = evict_reg;
        res_status_next = nta_pkg::ST_MISS;
        res_slot_next   = '0;
        res_id_next     = '0;
        res_weight_next = '0;
        res_evict_next  = '0;
        unique case (op_reg)
            nta_pkg::OP_RECV: begin
                if (id_match) begin
                    done            = 1'b1;
                    wr_upd          = 1'b1;
                    res_status_next = nta_pkg::ST_UPDATED;
                    res_slot_next   = nta_pkg::SLOT_W'(idx_reg);
                    res_id_next     = cur_id;
                    res_weight_next = upd_weight;
                end else if (!cur_valid) begin
                    done            = 1'b1;
                    wr_ins          = 1'b1;
                    res_status_next = nta_pkg::ST_INSERTED;
                    res_slot_next   = nta_pkg::SLOT_W'(idx_reg);
                    res_id_next     = src_reg;
                    res_weight_next = ins_weight;
                end else if (is_last) begin
                    done            = 1'b1;
                    res_status_next = nta_pkg::ST_FULL;
                end
            end
            nta_pkg::OP_TICK: begin
                wr_tick = cur_valid;
                if (cur_valid && (dec_weight == '0) && (evict_reg != nta_pkg::EVICT_MAX)) begin
                    evict_next = evict_reg + EW'(1);
                end
                done            = is_last;
                res_status_next = nta_pkg::ST_TICK;
                res_evict_next  = evict_next;
            end
            nta_pkg::OP_QUERY: begin
                if (tgt_match) begin
                    done            = 1'b1;
                    clr_unread      = cur_trusted && cur_unread;
                    res_status_next = (cur_trusted && cur_unread) ? nta_pkg::ST_HIT
                                                                  : nta_pkg::ST_MISS;
                    res_slot_next   = nta_pkg::SLOT_W'(idx_reg);
                    res_id_next     = cur_id;
                    res_weight_next = cur_weight;
                end else if (is_last) begin
                    done = 1'b1;
                end
            end
            default: done = 1'b1;
        endcase
    end

    assign sts.scan_done = done;

    // item latch, scan index and eviction count
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg    <= nta_pkg::op_t'(s_opcode);
            src_reg   <= s_source_id;
            dst_reg   <= s_dest_id;
            key_reg   <= s_query_key;
            idx_reg   <= '0;
            evict_reg <= '0;
        end else if (cmd.step) begin
            evict_reg <= evict_next;
            if (!done) begin
                idx_reg <= idx_reg + IW'(1);
            end
        end
    end

    // slot flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N; i++) begin
                valid_reg[i]   <= 1'b0;
                trusted_reg[i] <= 1'b0;
                unread_reg[i]  <= 1'b0;
            end
        end else if (cmd.step) begin
            if (wr_upd) begin
                unread_reg[idx_reg] <= 1'b1;
            end
            if (wr_ins) begin
                valid_reg[idx_reg]   <= 1'b1;
                trusted_reg[idx_reg] <= 1'b0;
                unread_reg[idx_reg]  <= 1'b1;
            end
            if (wr_tick) begin
                if (dec_weight == '0) begin
                    valid_reg[idx_reg]   <= 1'b0;
                    trusted_reg[idx_reg] <= 1'b0;
                    unread_reg[idx_reg]  <= 1'b0;
                end else begin
                    trusted_reg[idx_reg] <= (dec_weight > cfg.threshold);
                end
            end
            if (clr_unread) begin
                unread_reg[idx_reg] <= 1'b0;
            end
        end
    end

    // slot payload
    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            if (wr_upd) begin
                target_reg[idx_reg] <= dst_reg;
                weight_reg[idx_reg] <= upd_weight;
            end
            if (wr_ins) begin
                id_reg[idx_reg]     <= src_reg;
                target_reg[idx_reg] <= dst_reg;
                weight_reg[idx_reg] <= ins_weight;
            end
            if (wr_tick) begin
                weight_reg[idx_reg] <= dec_weight;
            end
        end
    end

    // result capture and output beat
    always_ff @(posedge aclk) begin
        if (cmd.step && done) begin
            res_status_reg <= res_status_next;
            res_slot_reg   <= res_slot_next;
            res_id_reg     <= res_id_next;
            res_weight_reg <= res_weight_next;
            res_evict_reg  <= res_evict_next;
        end
        if (cmd.load_out) begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_id_reg     <= res_id_reg;
            out_weight_reg <= res_weight_reg;
            out_evict_reg  <= res_evict_reg;
        end
    end

    assign m_status        = out_status_reg;
    assign m_slot          = out_slot_reg;
    assign m_entry_id      = out_id_reg;
    assign m_entry_weight  = out_weight_reg;
    assign m_evicted_count = out_evict_reg;

endmodule

[rtl/neighbor_table_with_aging_core.sv]
// Channel   | Direction | Ports                                               | Accepted when
// ----------+-----------+-----------------------------------------------------+--------------------
// input     | in        | s_opcode s_source_id s_dest_id s_query_key          | s_valid & s_ready
// result    | out       | m_status m_slot m_entry_id m_entry_weight m_evicted_count | m_valid & m_ready
// config    | in        | psel penable pwrite paddr pwdata prdata pready      | psel & penable & pwrite
//
// One beat in, one beat out (opcode 3 is taken and gives nothing).
// Receive and query scan slots one per cycle until a match or, for a receive,
// a free slot; a tick always walks all 16 slots.
// The scan through the slot table is the limit; one slot is read per cycle.
// A finished beat waits in the output register; a new item is taken meanwhile.
// Reset (aresetn, synchronous) empties the table and restores the registers.
module neighbor_table_with_aging_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [nta_pkg::OP_W-1:0]       s_opcode,
    input  logic [nta_pkg::ID_W-1:0]       s_source_id,
    input  logic [nta_pkg::ID_W-1:0]       s_dest_id,
    input  logic [nta_pkg::ID_W-1:0]       s_query_key,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [nta_pkg::STATUS_W-1:0]   m_status,
    output logic [nta_pkg::SLOT_W-1:0]     m_slot,
    output logic [nta_pkg::ID_W-1:0]       m_entry_id,
    output logic [nta_pkg::WT_W-1:0]       m_entry_weight,
    output logic [nta_pkg::EVICT_W-1:0]    m_evicted_count,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [nta_pkg::PADDR_W-1:0]    paddr,
    input  logic [nta_pkg::PDATA_W-1:0]    pwdata,
    output logic [nta_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);

    nta_pkg::cfg_t cfg;
    nta_pkg::cmd_t cmd;
    nta_pkg::sts_t sts;

    nta_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    nta_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    nta_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .cmd             (cmd),
        .sts             (sts),
        .s_opcode        (s_opcode),
        .s_source_id     (s_source_id),
        .s_dest_id       (s_dest_id),
        .s_query_key     (s_query_key),
        .m_status        (m_status),
        .m_slot          (m_slot),
        .m_entry_id      (m_entry_id),
        .m_entry_weight  (m_entry_weight),
        .m_evicted_count (m_evicted_count)
    );

endmodule

[tb/sv/tb_neighbor_table_with_aging_core.sv]
`timescale 1ns / 100ps

module tb_neighbor_table_with_aging_core;
    import nta_pkg::*;

    typedef struct packed {
        status_t            status;
        logic [SLOT_W-1:0]  slot;
        logic [ID_W-1:0]    id;
        logic [WT_W-1:0]    weight;
        logic [EVICT_W-1:0] evicted;
    } outcome_t;

    // one line of the directed table; reps repeats the beat, stride bumps the source id
    typedef struct packed {
        op_t             op;
        logic [ID_W-1:0] src;
        logic [ID_W-1:0] dst;
        logic [ID_W-1:0] key;
        logic [ID_W-1:0] stride;
        logic [4:0]      reps;
        logic            typed;
        outcome_t        res;
    } stim_row_t;

    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 190;

    logic                 aclk            = 1'b0;
    logic                 aresetn         = 1'b0;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic [OP_W-1:0]      s_opcode        = '0;
    logic [ID_W-1:0]      s_source_id     = '0;
    logic [ID_W-1:0]      s_dest_id       = '0;
    logic [ID_W-1:0]      s_query_key     = '0;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic [STATUS_W-1:0]  m_status;
    logic [SLOT_W-1:0]    m_slot;
    logic [ID_W-1:0]      m_entry_id;
    logic [WT_W-1:0]      m_entry_weight;
    logic [EVICT_W-1:0]   m_evicted_count;
    logic                 psel            = 1'b0;
    logic                 penable         = 1'b0;
    logic                 pwrite          = 1'b0;
    logic [PADDR_W-1:0]   paddr           = '0;
    logic [PDATA_W-1:0]   pwdata          = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    neighbor_table_with_aging_core u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_source_id     (s_source_id),
        .s_dest_id       (s_dest_id),
        .s_query_key     (s_query_key),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_slot          (m_slot),
        .m_entry_id      (m_entry_id),
        .m_entry_weight  (m_entry_weight),
        .m_evicted_count (m_evicted_count),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5 aclk = ~aclk;

    // shadow copy of the neighbor table and its registers
    logic            tbl_valid   [ENTRIES];
    logic [ID_W-1:0] tbl_id      [ENTRIES];
    logic [ID_W-1:0] tbl_target  [ENTRIES];
    logic [WT_W-1:0] tbl_weight  [ENTRIES];
    logic            tbl_trusted [ENTRIES];
    logic            tbl_unread  [ENTRIES];
    logic [WT_W-1:0] cfg_thr = THRESHOLD_RST;
    logic [WT_W-1:0] cfg_inc = INCREMENT_RST;
    logic [WT_W-1:0] cfg_cap = CAP_RST;

    outcome_t  due_results [$];
    stim_row_t dir_rows [$];
    outcome_t  head_result;
    int        idle_pct = 32;
    bit        hold_req = 1'b0;
    int        errors   = 0;

    function automatic outcome_t make_outcome(status_t st, int slot, int id, int weight,
                                              int evicted);
        outcome_t o;
        o.status  = st;
        o.slot    = SLOT_W'(slot);
        o.id      = ID_W'(id);
        o.weight  = WT_W'(weight);
        o.evicted = EVICT_W'(evicted);
        return o;
    endfunction

    // sum is formed one bit wider so it never wraps before the cap
    function automatic logic [WT_W-1:0] clamp_weight(logic [WT_W:0] w);
        return (w > {1'b0, cfg_cap}) ? cfg_cap : w[WT_W-1:0];
    endfunction

    function automatic logic [ID_W-1:0] pick_id(int pool);
        return ($urandom_range(3) != 0) ? ID_W'($urandom_range(pool - 1))
                                        : ID_W'($urandom_range(255));
    endfunction

    // apply one item to the shadow table and work out its result
    task automatic advance_table(input op_t op, input logic [ID_W-1:0] src, dst, key,
                                 output outcome_t res, output logic produced);
        bit done;
        int cnt;
        done     = 1'b0;
        cnt      = 0;
        produced = 1'b1;
        res      = '0;
        case (op)
            OP_RECV: begin
                res.status = ST_FULL;
                for (int i = 0; i < ENTRIES && !done; i++) begin
                    if (tbl_valid[i] && tbl_id[i] == src) begin
                        tbl_target[i] = dst;
                        tbl_unread[i] = 1'b1;
                        tbl_weight[i] = clamp_weight({1'b0, tbl_weight[i]} + {1'b0, cfg_inc});
                        res  = make_outcome(ST_UPDATED, i, src, tbl_weight[i], 0);
                        done = 1'b1;
                    end else if (!tbl_valid[i]) begin
                        tbl_valid[i]   = 1'b1;
                        tbl_id[i]      = src;
                        tbl_target[i]  = dst;
                        tbl_unread[i]  = 1'b1;
                        tbl_trusted[i] = 1'b0;
                        tbl_weight[i]  = clamp_weight({1'b0, cfg_inc});
                        res  = make_outcome(ST_INSERTED, i, src, tbl_weight[i], 0);
                        done = 1'b1;
                    end
                end
            end
            OP_TICK: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (tbl_valid[i]) begin
                        if (tbl_weight[i] != '0) tbl_weight[i] = tbl_weight[i] - 1'b1;
                        if (tbl_weight[i] == '0) begin
                            tbl_valid[i]   = 1'b0;
                            tbl_trusted[i] = 1'b0;
                            tbl_unread[i]  = 1'b0;
                            if (cnt < 31) cnt++;
                        end else begin
                            tbl_trusted[i] = (tbl_weight[i] > cfg_thr);
                        end
                    end
                end
                res = make_outcome(ST_TICK, 0, 0, 0, cnt);
            end
            OP_QUERY: begin
                res.status = ST_MISS;
                for (int i = 0; i < ENTRIES && !done; i++) begin
                    if (tbl_valid[i] && tbl_target[i] == key) begin
                        if (tbl_trusted[i] && tbl_unread[i]) begin
                            tbl_unread[i] = 1'b0;
                            res = make_outcome(ST_HIT, i, tbl_id[i], tbl_weight[i], 0);
                        end else begin
                            res = make_outcome(ST_MISS, i, tbl_id[i], tbl_weight[i], 0);
                        end
                        done = 1'b1;
                    end
                end
            end
            default: produced = 1'b0;
        endcase
    endtask

    // offer one beat, wait for it to be taken, then log what it should produce
    task automatic send_beat(input op_t op, input logic [ID_W-1:0] src, dst, key,
                             input logic typed, input outcome_t fixed_res);
        outcome_t pred;
        logic     produced;
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_opcode    <= op;
        s_source_id <= src;
        s_dest_id   <= dst;
        s_query_key <= key;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        advance_table(op, src, dst, key, pred, produced);
        if (produced) due_results.push_back(typed ? fixed_res : pred);
    endtask

    // stop sending, wait until every pending result is checked, then wait extra more clock edges
    task automatic drain(input int extra);
        s_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= PDATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_THRESHOLD: cfg_thr = WT_W'(value);
            REG_INCREMENT: cfg_inc = WT_W'(value);
            REG_CAP:       cfg_cap = WT_W'(value);
            default: ;
        endcase
    endtask

    task automatic add_row(input op_t op, input int src, dst, key, reps, stride,
                           input logic typed, input outcome_t res);
        stim_row_t row;
        row.op     = op;
        row.src    = ID_W'(src);
        row.dst    = ID_W'(dst);
        row.key    = ID_W'(key);
        row.reps   = 5'(reps);
        row.stride = ID_W'(stride);
        row.typed  = typed;
        row.res    = res;
        dir_rows.push_back(row);
    endtask

    // result side: random back-pressure, plus one long hold-off on request
    initial begin : result_sink
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    // compare every result beat with the oldest pending outcome
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                $error("result beat with nothing pending: status %0d slot %0d",
                       m_status, m_slot);
                errors++;
            end else begin
                head_result = due_results.pop_front();
                if (m_status !== head_result.status) begin
                    $error("status: expected %0d actual %0d", head_result.status, m_status);
                    errors++;
                end
                if (m_slot !== head_result.slot) begin
                    $error("slot: expected %0d actual %0d", head_result.slot, m_slot);
                    errors++;
                end
                if (m_entry_id !== head_result.id) begin
                    $error("entry_id: expected %0d actual %0d", head_result.id, m_entry_id);
                    errors++;
                end
                if (m_entry_weight !== head_result.weight) begin
                    $error("entry_weight: expected %0d actual %0d",
                           head_result.weight, m_entry_weight);
                    errors++;
                end
                if (m_evicted_count !== head_result.evicted) begin
                    $error("evicted_count: expected %0d actual %0d",
                           head_result.evicted, m_evicted_count);
                    errors++;
                end
            end
        end
    end

    initial begin : stimulus
        int        thr, inc, cap, tick_pct, n, r;
        op_t       op;
        stim_row_t row;
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_valid[i]   = 1'b0;
            tbl_id[i]      = '0;
            tbl_target[i]  = '0;
            tbl_weight[i]  = '0;
            tbl_trusted[i] = 1'b0;
            tbl_unread[i]  = 1'b0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed beats at reset settings
        add_row(OP_QUERY, 0, 0, 0, 1, 0, 1'b1, make_outcome(ST_MISS, 0, 0, 0, 0));
        add_row(OP_TICK, 0, 0, 0, 1, 0, 1'b1, make_outcome(ST_TICK, 0, 0, 0, 0));
        add_row(OP_RECV, 0, 0, 0, 1, 0, 1'b1, make_outcome(ST_INSERTED, 0, 0, 10, 0));
        add_row(OP_RECV, 255, 255, 0, 1, 0, 1'b1, make_outcome(ST_INSERTED, 1, 255, 10, 0));
        add_row(OP_RECV, 0, 255, 0, 1, 0, 1'b1, make_outcome(ST_UPDATED, 0, 0, 20, 0));
        add_row(OP_NONE, 255, 255, 255, 1, 0, 1'b0, '0);
        // first target match is untrusted
        add_row(OP_QUERY, 0, 0, 255, 1, 0, 1'b1, make_outcome(ST_MISS, 0, 0, 20, 0));
        add_row(OP_RECV, 0, 255, 0, 4, 0, 1'b0, '0);
        add_row(OP_TICK, 0, 0, 0, 1, 0, 1'b1, make_outcome(ST_TICK, 0, 0, 0, 0));
        add_row(OP_QUERY, 0, 0, 255, 1, 0, 1'b1, make_outcome(ST_HIT, 0, 0, 59, 0));
        // same entry again: already read
        add_row(OP_QUERY, 0, 0, 255, 1, 0, 1'b1, make_outcome(ST_MISS, 0, 0, 59, 0));
        add_row(OP_RECV, 1, 90, 0, 14, 1, 1'b0, '0);
        // every slot taken
        add_row(OP_RECV, 200, 0, 0, 1, 0, 1'b1, make_outcome(ST_FULL, 0, 0, 0, 0));
        add_row(OP_QUERY, 0, 0, 90, 1, 0, 1'b0, '0);
        add_row(OP_RECV, 255, 90, 0, 1, 0, 1'b0, '0);
        add_row(OP_QUERY, 0, 0, 165, 1, 0, 1'b1, make_outcome(ST_MISS, 0, 0, 0, 0));
        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            for (int j = 0; j < int'(row.reps); j++) begin
                send_beat(row.op, ID_W'(int'(row.src) + int'(row.stride) * j),
                          row.dst, row.key, row.typed, row.res);
            end
        end
        drain(SETTLE_CYCLES);

        // random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin thr = 0;   inc = 1;   cap = 1;   tick_pct = 10; end
                1: begin thr = 100; inc = 100; cap = 127; tick_pct = 15; end
                2: begin thr = 0;   inc = 100; cap = 127; tick_pct = 15; end
                // cap drops under stored weights; increment above cap
                3: begin thr = 30;  inc = 40;  cap = 20;  tick_pct = 15; end
                4: begin thr = 3;   inc = 2;   cap = 5;   tick_pct = 10; end
                default: begin
                    thr      = $urandom_range(100);
                    inc      = $urandom_range(100, 1);
                    cap      = $urandom_range(127, 1);
                    tick_pct = $urandom_range(30, 5);
                end
            endcase
            write_reg(REG_THRESHOLD, thr);
            write_reg(REG_INCREMENT, inc);
            write_reg(REG_CAP, cap);
            idle_pct = (p == 2) ? 0 : 32;
            if (p == 1) hold_req = 1'b1;
            n = 0;
            while (n < PHASE_ITEMS) begin
                if (p == 4 && n == PHASE_ITEMS / 2) drain(1);
                r = $urandom_range(99);
                if (r < tick_pct)           op = OP_TICK;
                else if (r < tick_pct + 30) op = OP_QUERY;
                else if (r < 96)            op = OP_RECV;
                else                        op = OP_NONE;
                send_beat(op, pick_id(20), pick_id(6), pick_id(6), 1'b0, '0);
                if (op != OP_NONE) n++;
            end
            drain(SETTLE_CYCLES);
        end

        drain(40);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
